>>> sv/tmf_pkg.sv
// ---------------------------------------------------------------------------
// tmf_pkg
// Shared constants, types and helpers of the trimmed mean filter.
// ---------------------------------------------------------------------------
package tmf_pkg;

    localparam int MaxSamples = 16;
    localparam int SampleW    = 12;
    localparam int ChanW      = 4;
    localparam int AvgW       = 13;
    localparam int CntRegW    = 5;
    localparam int TrimW      = 4;
    localparam int CntW       = $clog2(MaxSamples + 1);
    localparam int IdxW       = $clog2(MaxSamples);
    localparam int SumW       = SampleW + IdxW;
    localparam int DivStepW   = $clog2(SumW);
    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QLvlW      = $clog2(QDepth + 1);
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 8;
    localparam int InTdataW   = 16;
    localparam int OutTdataW  = 24;
    localparam int AvgMax     = 8190;

    localparam logic [CfgIdxW-1:0] RegSampleCount = 2'd0;
    localparam logic [CfgIdxW-1:0] RegTrimCount   = 2'd1;

    localparam logic [CntRegW-1:0] SampleCountRst = 5'd16;
    localparam logic [TrimW-1:0]   TrimCountRst   = 4'd4;

    typedef logic [SampleW-1:0] sample_t;
    typedef logic [ChanW-1:0]   chan_t;

    // live configuration seen by both halves
    typedef struct packed {
        logic [CntW-1:0]  n;
        logic [TrimW-1:0] trim;
    } cfg_t;

    // one queued word, already classified by the front end
    typedef struct packed {
        sample_t sample;
        chan_t   chan;
        logic    first;
        logic    last;
    } qent_t;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_WB   = 4'b1000
    } back_state_t;

    // zero counts as one, anything above the store depth saturates
    function automatic logic [CntW-1:0] eff_count(input logic [CntRegW-1:0] c);
        logic [CntW-1:0] r;
        if (c == '0) begin
            r = CntW'(1);
        end else if (int'(c) > MaxSamples) begin
            r = CntW'(MaxSamples);
        end else begin
            r = CntW'(c);
        end
        return r;
    endfunction

endpackage

>>> sv/tmf_front.sv
// ---------------------------------------------------------------------------
// tmf_front
// Accepts sample words, tracks the set fill level and tags each word as
// first and/or last of its set before it enters the queue.
// ---------------------------------------------------------------------------
module tmf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tmf_pkg::sample_t           in_sample,
    input  tmf_pkg::chan_t             in_chan,
    input  tmf_pkg::cfg_t              cfg,
    output logic                       q_wr_valid,
    input  logic                       q_wr_ready,
    output tmf_pkg::qent_t             q_wr_ent
);

    logic [tmf_pkg::CntW-1:0] fill_reg, fill_next;
    tmf_pkg::chan_t           tag_reg, tag_next;
    logic                     accept;
    logic                     first;
    logic                     last;
    logic [tmf_pkg::CntW-1:0] fill_inc;

    assign accept     = in_valid && q_wr_ready;
    assign in_ready   = q_wr_ready;
    assign q_wr_valid = in_valid;

    // a fill level at or above the count (count lowered mid-set) restarts the set
    assign first    = (fill_reg >= cfg.n) || (fill_reg == '0);
    assign fill_inc = (first ? '0 : fill_reg) + tmf_pkg::CntW'(1);
    assign last     = (fill_inc >= cfg.n);

    always_comb begin
        fill_next = fill_reg;
        tag_next  = tag_reg;
        if (accept) begin
            fill_next = last ? '0 : fill_inc;
            if (first) begin
                tag_next = in_chan;
            end
        end
    end

    always_comb begin
        q_wr_ent.sample = in_sample;
        q_wr_ent.chan   = first ? in_chan : tag_reg;
        q_wr_ent.first  = first;
        q_wr_ent.last   = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            tag_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            tag_reg  <= tag_next;
        end
    end

endmodule

>>> sv/tmf_queue.sv
// ---------------------------------------------------------------------------
// tmf_queue
// Short first-in first-out buffer between the front end and the sorter.
// ---------------------------------------------------------------------------
module tmf_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  tmf_pkg::qent_t             wr_ent,
    output logic                       rd_valid,
    input  logic                       rd_ready,
    output tmf_pkg::qent_t             rd_ent,
    output logic [tmf_pkg::QLvlW-1:0]  level
);

    tmf_pkg::qent_t            store_reg [tmf_pkg::QDepth];
    logic [tmf_pkg::QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tmf_pkg::QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tmf_pkg::QLvlW-1:0] level_reg, level_next;
    logic                      push;
    logic                      pop;

    assign wr_ready = (level_reg != tmf_pkg::QLvlW'(tmf_pkg::QDepth));
    assign rd_valid = (level_reg != '0);
    assign rd_ent   = store_reg[rd_ptr_reg];
    assign level    = level_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + tmf_pkg::QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + tmf_pkg::QPtrW'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + tmf_pkg::QLvlW'(1);
        end else if (pop && !push) begin
            level_next = level_reg - tmf_pkg::QLvlW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= wr_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

>>> sv/tmf_back.sv
// ---------------------------------------------------------------------------
// tmf_back
// Insertion-sorting cell row, trimmed sum over the sorted row, restoring
// divider and the result output register.
// ---------------------------------------------------------------------------
module tmf_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  tmf_pkg::qent_t                 q_ent,
    input  tmf_pkg::cfg_t                  cfg,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tmf_pkg::AvgW-1:0]       out_avg,
    output tmf_pkg::chan_t                 out_chan,
    output logic                           out_err
);

    localparam int M = tmf_pkg::MaxSamples;

    tmf_pkg::back_state_t         state_reg, state_next;
    logic [tmf_pkg::CntW-1:0]     cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;

    tmf_pkg::sample_t             cells_reg  [M];
    tmf_pkg::sample_t             cells_next [M];
    logic [M-1:0]                 gt;

    logic [tmf_pkg::CntW-1:0]     k_reg;
    logic [tmf_pkg::CntW-1:0]     n_reg;
    logic [tmf_pkg::CntW-1:0]     lo_reg;
    logic [tmf_pkg::CntW-1:0]     hi_reg;
    logic [tmf_pkg::CntW-1:0]     div_reg;
    logic [tmf_pkg::SumW-1:0]     acc_reg;
    logic [tmf_pkg::SumW-1:0]     quo_reg;
    logic [tmf_pkg::CntW-1:0]     rem_reg;
    logic [tmf_pkg::DivStepW-1:0] step_reg;
    tmf_pkg::chan_t               chan_reg;
    logic                         err_reg;
    logic [tmf_pkg::AvgW-1:0]     avg_out_reg;
    tmf_pkg::chan_t               chan_out_reg;
    logic                         err_out_reg;

    logic                         pop;
    logic [tmf_pkg::CntW-1:0]     cnt_base;
    logic                         err_now;
    logic [tmf_pkg::CntW-1:0]     half_now;
    logic                         in_range;
    logic [tmf_pkg::SumW-1:0]     acc_next;
    logic [tmf_pkg::CntW:0]       rem_sh;
    logic                         ge;
    logic                         sum_done;
    logic                         div_done;
    logic                         wb_go;

    assign q_ready  = (state_reg == tmf_pkg::S_LOAD);
    assign pop      = q_ready && q_valid;
    assign cnt_base = q_ent.first ? '0 : cnt_reg;
    assign err_now  = (int'(cfg.trim) >= int'(cfg.n));
    assign half_now = tmf_pkg::CntW'(cfg.trim >> 1);

    // sorted row: cells below the held count are valid, the rest act as +inf
    for (genvar gi = 0; gi < M; gi++) begin : g_cell
        tmf_pkg::sample_t below;
        tmf_pkg::sample_t above;
        logic             gt_below;
        if (gi == 0) begin : g_bottom
            assign below    = q_ent.sample;
            assign gt_below = 1'b0;
        end else begin : g_mid
            assign below    = cells_reg[gi-1];
            assign gt_below = gt[gi-1];
        end
        if (gi == M - 1) begin : g_top
            assign above = cells_reg[gi];
        end else begin : g_low
            assign above = cells_reg[gi+1];
        end
        assign gt[gi] = (tmf_pkg::CntW'(gi) >= cnt_base) || (cells_reg[gi] > q_ent.sample);
        always_comb begin
            cells_next[gi] = cells_reg[gi];
            if (pop) begin
                cells_next[gi] = gt[gi] ? (gt_below ? below : q_ent.sample) : cells_reg[gi];
            end else if (state_reg == tmf_pkg::S_SUM) begin
                cells_next[gi] = above;
            end
        end
    end

    // ranks below lo and from hi upwards are the trimmed extremes
    assign in_range = (k_reg >= lo_reg) && (k_reg < hi_reg);
    assign acc_next = acc_reg + (in_range ? tmf_pkg::SumW'(cells_reg[0]) : '0);
    assign sum_done = (k_reg == n_reg - tmf_pkg::CntW'(1));

    assign rem_sh   = {rem_reg, quo_reg[tmf_pkg::SumW-1]};
    assign ge       = (rem_sh >= {1'b0, div_reg});
    assign div_done = (step_reg == tmf_pkg::DivStepW'(tmf_pkg::SumW - 1));

    assign wb_go    = (state_reg == tmf_pkg::S_WB) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            tmf_pkg::S_LOAD: begin
                if (pop) begin
                    cnt_next = cnt_base + tmf_pkg::CntW'(1);
                    if (q_ent.last) begin
                        state_next = err_now ? tmf_pkg::S_WB : tmf_pkg::S_SUM;
                    end
                end
            end
            tmf_pkg::S_SUM: begin
                if (sum_done) begin
                    state_next = tmf_pkg::S_DIV;
                end
            end
            tmf_pkg::S_DIV: begin
                if (div_done) begin
                    state_next = tmf_pkg::S_WB;
                end
            end
            tmf_pkg::S_WB: begin
                if (wb_go) begin
                    out_valid_next = 1'b1;
                    state_next     = tmf_pkg::S_LOAD;
                end
            end
            default: begin
                state_next = tmf_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < M; i++) begin
            cells_reg[i] <= cells_next[i];
        end
        if (pop && q_ent.last) begin
            n_reg    <= cfg.n;
            lo_reg   <= half_now;
            hi_reg   <= cfg.n - half_now;
            div_reg  <= cfg.n - tmf_pkg::CntW'(cfg.trim);
            chan_reg <= q_ent.chan;
            err_reg  <= err_now;
            k_reg    <= '0;
            acc_reg  <= '0;
        end
        if (state_reg == tmf_pkg::S_SUM) begin
            acc_reg <= acc_next;
            k_reg   <= k_reg + tmf_pkg::CntW'(1);
            if (sum_done) begin
                quo_reg  <= acc_next;
                rem_reg  <= '0;
                step_reg <= '0;
            end
        end
        if (state_reg == tmf_pkg::S_DIV) begin
            rem_reg  <= ge ? tmf_pkg::CntW'(rem_sh - {1'b0, div_reg})
                           : tmf_pkg::CntW'(rem_sh);
            quo_reg  <= {quo_reg[tmf_pkg::SumW-2:0], ge};
            step_reg <= step_reg + tmf_pkg::DivStepW'(1);
        end
        if (wb_go) begin
            avg_out_reg  <= err_reg ? '0 : quo_reg[tmf_pkg::AvgW-1:0];
            chan_out_reg <= chan_reg;
            err_out_reg  <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmf_pkg::S_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_avg   = avg_out_reg;
    assign out_chan  = chan_out_reg;
    assign out_err   = err_out_reg;

endmodule

>>> sv/trimmed_mean_filter_top.sv
// ---------------------------------------------------------------------------
// trimmed_mean_filter_top
// Trimmed mean of a set of converter samples per channel.
//
// Input words (s_*) carry one 12-bit sample and its channel. The channel of
// the first word of a set is kept. After sample_count words the set is
// sorted, trim_count/2 values are dropped at each end, the rest summed and
// divided by sample_count - trim_count. One result word (m_*) follows per
// set; m_tuser flags a trim count not below the sample count (average 0).
// Registers must be written on the cfg_* channel by the user only while no
// set is in flight (not enforced by the block): index 0 is sample_count, index 1 is trim_count.
// Each word is sorted into a cell row as it leaves a four-word queue, so
// words are taken one per cycle while the back end is loading. Closing a set
// costs summation over the row, 16 divider steps and one write-back, during
// which the queue absorbs up to four further words before s_tready drops.
// Reset (aresetn low, synchronous) empties the queue, drops any partial set
// and restores sample_count 16, trim_count 4. A stalled receiver holds the
// result in the output register; the next set may load meanwhile.
// ---------------------------------------------------------------------------
module trimmed_mean_filter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tmf_pkg::InTdataW-1:0]    s_tdata,   // sample[11:0], channel[15:12]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmf_pkg::OutTdataW-1:0]   m_tdata,   // average[12:0], channel_out[16:13], zero
    output logic [0:0]                      m_tuser,   // error[0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tmf_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [tmf_pkg::CfgDataW-1:0]    cfg_data
);

    logic [tmf_pkg::CntRegW-1:0] sample_count_reg;
    logic [tmf_pkg::TrimW-1:0]   trim_count_reg;
    tmf_pkg::cfg_t               cfg;

    logic                        fq_valid, fq_ready;
    tmf_pkg::qent_t              fq_ent;
    logic                        qb_valid, qb_ready;
    tmf_pkg::qent_t              qb_ent;
    logic [tmf_pkg::QLvlW-1:0]   q_level;

    logic [tmf_pkg::AvgW-1:0]    avg;
    tmf_pkg::chan_t              chan_out;
    logic                        err;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= tmf_pkg::SampleCountRst;
            trim_count_reg   <= tmf_pkg::TrimCountRst;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tmf_pkg::RegSampleCount: sample_count_reg <= cfg_data[tmf_pkg::CntRegW-1:0];
                tmf_pkg::RegTrimCount:   trim_count_reg   <= cfg_data[tmf_pkg::TrimW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.n    = tmf_pkg::eff_count(sample_count_reg);
    assign cfg.trim = trim_count_reg;

    tmf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[tmf_pkg::SampleW-1:0]),
        .in_chan    (s_tdata[tmf_pkg::SampleW +: tmf_pkg::ChanW]),
        .cfg        (cfg),
        .q_wr_valid (fq_valid),
        .q_wr_ready (fq_ready),
        .q_wr_ent   (fq_ent)
    );

    tmf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_ent   (fq_ent),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_ent   (qb_ent),
        .level    (q_level)
    );

    tmf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_ent     (qb_ent),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_avg   (avg),
        .out_chan  (chan_out),
        .out_err   (err)
    );

    assign m_tdata = {{(tmf_pkg::OutTdataW - tmf_pkg::AvgW - tmf_pkg::ChanW){1'b0}},
                      chan_out, avg};
    assign m_tuser = err;

    // an error word always carries a zero average
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[tmf_pkg::AvgW-1:0] == '0))
        else $error("error result with non-zero average");

    // the trimmed mean never exceeds twice the largest possible sample value
    a_avg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[tmf_pkg::AvgW-1:0]) <= tmf_pkg::AvgMax))
        else $error("average out of range");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // queue level stays within depth and full blocks the input
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(q_level) <= tmf_pkg::QDepth) &&
        (s_tready == (q_level != tmf_pkg::QLvlW'(tmf_pkg::QDepth))))
        else $error("queue level inconsistent with input ready");

endmodule
